[rtl/sh256_pkg.sv]
// Shared types, constants and functions for the SHA-256 stream hasher.
`default_nettype none

package sh256_pkg;

  typedef logic [7:0][31:0] sh256_hash_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } sh256_state_t;

  typedef enum logic [1:0] {
    PH_ABSORB,
    PH_EXTRA,
    PH_FINAL
  } sh256_phase_t;

  typedef struct packed {
    logic load;
    logic step;
    logic fold;
    logic iv;
  } sh256_ctl_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LAST_FILL = 6'd63;
  localparam logic [5:0] LEN_FILL_MAX = 6'd56;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_INDEX = 3'd7;

  localparam sh256_hash_t INIT_HASH = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] t);
    case (t)
      6'd0:  round_k = 32'h428a2f98;
      6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf;
      6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b;
      6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4;
      6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98;
      6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be;
      6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74;
      6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7;
      6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1;
      6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6;
      6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f;
      6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc;
      6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152;
      6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8;
      6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3;
      6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351;
      6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85;
      6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc;
      6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354;
      6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e;
      6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1;
      6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70;
      6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819;
      6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585;
      6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116;
      6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c;
      6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3;
      6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f;
      6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee;
      6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814;
      6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa;
      6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;
      default: round_k = 32'hc67178f2;
    endcase
  endfunction

endpackage

`default_nettype wire

[rtl/sh256_core.sv]
// SHA-256 round engine: working variables, one round per cycle, and the chaining hash.
`default_nettype none

module sh256_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire sh256_pkg::sh256_ctl_t ctl,
  input  wire logic [5:0]          rnd,
  input  wire logic [31:0]         w,
  output sh256_pkg::sh256_hash_t   hash
);
  import sh256_pkg::*;

  logic [31:0] a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r;
  sh256_hash_t hash_r;

  logic [31:0] s0, s1, ch, maj, t1, t2;

  always_comb begin
    s1  = rotr(e_r, 6) ^ rotr(e_r, 11) ^ rotr(e_r, 25);
    ch  = (e_r & f_r) ^ (~e_r & g_r);
    t1  = h_r + s1 + ch + round_k(rnd) + w;
    s0  = rotr(a_r, 2) ^ rotr(a_r, 13) ^ rotr(a_r, 22);
    maj = (a_r & b_r) ^ (a_r & c_r) ^ (b_r & c_r);
    t2  = s0 + maj;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a_r <= hash_r[0];
      b_r <= hash_r[1];
      c_r <= hash_r[2];
      d_r <= hash_r[3];
      e_r <= hash_r[4];
      f_r <= hash_r[5];
      g_r <= hash_r[6];
      h_r <= hash_r[7];
    end else if (ctl.step) begin
      h_r <= g_r;
      g_r <= f_r;
      f_r <= e_r;
      e_r <= d_r + t1;
      d_r <= c_r;
      c_r <= b_r;
      b_r <= a_r;
      a_r <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.iv) begin
      hash_r <= INIT_HASH;
    end else if (ctl.fold) begin
      hash_r[0] <= hash_r[0] + a_r;
      hash_r[1] <= hash_r[1] + b_r;
      hash_r[2] <= hash_r[2] + c_r;
      hash_r[3] <= hash_r[3] + d_r;
      hash_r[4] <= hash_r[4] + e_r;
      hash_r[5] <= hash_r[5] + f_r;
      hash_r[6] <= hash_r[6] + g_r;
      hash_r[7] <= hash_r[7] + h_r;
    end
  end

  assign hash = hash_r;

endmodule

`default_nettype wire

[rtl/sha256_stream_hasher.sv]
// SHA-256 stream hasher top level: byte packing, padding, message schedule and control.
//
// Usage: message bytes enter one word at a time on the in_ channel. in_tuser[0]
// set means in_tdata carries a byte; clear means it carries none and at most ends the message.
// in_tlast ends the message: padding and the 64-bit bit length are appended and
// the eight digest words H0..H7 leave on the out_ channel, out_tuser giving the
// index and out_tlast marking H7. The hash then restarts from the initial value.
// Sequence: a byte that does not complete a block is only stored; the byte that
// completes a 64-byte block is accepted, then load, 64 rounds of the single
// round unit and fold follow. An end word is followed by padding and one
// compression, or by two compressions when its own byte fills a block or the
// tail leaves no room for the length, then by the 8 digest words, one
// per cycle while the receiver takes them. in_tready is high only while the block
// is idle. If the receiver stalls, the current digest word holds on out_tdata and
// nothing else moves. Synchronous reset returns to the initial hash, an empty
// block and a zero length; no clearing pass is needed.
`default_nettype none

module sha256_stream_hasher (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic [0:0]  in_tuser,   // [0] byte_valid
  input  wire logic        in_tlast,   // end_of_message
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] digest_word
  output logic [2:0]       out_tuser,  // [2:0] word_index
  output logic             out_tlast   // last_word
);
  import sh256_pkg::*;

  sh256_state_t state_r, state_nxt;
  sh256_phase_t phase_r;
  sh256_ctl_t   ctl;
  sh256_hash_t  hash;

  logic [31:0] blk_r [16];
  logic [5:0]  fill_r;
  logic [60:0] len_r;
  logic [5:0]  rnd_r;
  logic [2:0]  idx_r;
  logic        last_pend_r;

  logic        in_acc, out_acc;
  logic [63:0] bit_len;
  logic [31:0] sched_w;

  function automatic logic [31:0] merge_byte(input logic [31:0] word, input logic [7:0] b,
                                             input logic [1:0] pos);
    case (pos)
      2'd0:    merge_byte = {b, 24'h0};
      2'd1:    merge_byte = {word[31:24], b, word[15:0]};
      2'd2:    merge_byte = {word[31:16], b, word[7:0]};
      default: merge_byte = {word[31:8], b};
    endcase
  endfunction

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;
  assign bit_len = {len_r, 3'b000};
  assign sched_w = blk_r[0] + sig0(blk_r[1]) + blk_r[9] + sig1(blk_r[14]);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser[0] && fill_r == LAST_FILL) begin
            state_nxt = ST_LOAD;
          end else if (in_tlast) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD:   state_nxt = ST_LOAD;
      ST_LEN:   state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = ST_ROUND;
      ST_ROUND: begin
        if (rnd_r == LAST_ROUND) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        case (phase_r)
          PH_ABSORB: state_nxt = last_pend_r ? ST_PAD : ST_IDLE;
          PH_EXTRA:  state_nxt = ST_LEN;
          default:   state_nxt = ST_OUT;
        endcase
      end
      ST_OUT: begin
        if (out_acc && idx_r == LAST_INDEX) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    ctl        = '0;
    case (state_r)
      ST_IDLE:  in_tready = 1'b1;
      ST_LOAD:  ctl.load = 1'b1;
      ST_ROUND: ctl.step = 1'b1;
      ST_FOLD:  ctl.fold = 1'b1;
      ST_OUT: begin
        out_tvalid = 1'b1;
        ctl.iv     = out_acc && idx_r == LAST_INDEX;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      len_r       <= '0;
      rnd_r       <= '0;
      idx_r       <= '0;
      last_pend_r <= 1'b0;
      phase_r     <= PH_ABSORB;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            last_pend_r <= in_tlast;
            phase_r     <= PH_ABSORB;
            if (in_tuser[0]) begin
              fill_r <= fill_r + 6'd1;
              len_r  <= len_r + 61'd1;
            end
          end
        end
        ST_PAD: begin
          last_pend_r <= 1'b0;
          phase_r     <= (fill_r >= LEN_FILL_MAX) ? PH_EXTRA : PH_FINAL;
        end
        ST_LEN:   phase_r <= PH_FINAL;
        ST_LOAD:  rnd_r <= '0;
        ST_ROUND: rnd_r <= rnd_r + 6'd1;
        ST_OUT: begin
          if (out_acc) begin
            idx_r <= idx_r + 3'd1;
            if (idx_r == LAST_INDEX) begin
              fill_r <= '0;
              len_r  <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // block buffer doubles as the 16-word schedule window during rounds
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_tuser[0]) begin
          for (int i = 0; i < 16; i++) begin
            if (fill_r[5:2] == 4'(i)) begin
              blk_r[i] <= merge_byte(blk_r[i], in_tdata, fill_r[1:0]);
            end
          end
        end
      end
      ST_PAD: begin
        for (int i = 0; i < 16; i++) begin
          if (fill_r[5:2] == 4'(i)) begin
            blk_r[i] <= merge_byte(blk_r[i], PAD_BYTE, fill_r[1:0]);
          end else if (4'(i) > fill_r[5:2]) begin
            if (fill_r < LEN_FILL_MAX && i == 14) begin
              blk_r[i] <= bit_len[63:32];
            end else if (fill_r < LEN_FILL_MAX && i == 15) begin
              blk_r[i] <= bit_len[31:0];
            end else begin
              blk_r[i] <= '0;
            end
          end
        end
      end
      ST_LEN: begin
        for (int i = 0; i < 14; i++) begin
          blk_r[i] <= '0;
        end
        blk_r[14] <= bit_len[63:32];
        blk_r[15] <= bit_len[31:0];
      end
      ST_ROUND: begin
        for (int i = 0; i < 15; i++) begin
          blk_r[i] <= blk_r[i + 1];
        end
        blk_r[15] <= sched_w;
      end
      default: ;
    endcase
  end

  sh256_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .rnd   (rnd_r),
    .w     (blk_r[0]),
    .hash  (hash)
  );

  assign out_tdata = hash[idx_r];
  assign out_tuser = idx_r;
  assign out_tlast = (idx_r == LAST_INDEX);

endmodule

`default_nettype wire

[tb/sha256_checker.sv]
// Checker for the SHA-256 stream hasher: predicts each digest from the input words and compares.
module sha256_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic [0:0]  in_tuser,   // [0] byte_valid
  input  wire logic        in_tlast,   // end_of_message
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [31:0] out_tdata,  // [31:0] digest_word
  input  wire logic [2:0]  out_tuser,  // [2:0] word_index
  input  wire logic        out_tlast,  // last_word
  output int               mismatches,
  output int               words_owed
);
  import sh256_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_entry_t;

  localparam logic [0:63][31:0] ROUND_CONST = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [0:7][31:0] START_HASH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic [31:0]   chain [8];
  logic [31:0]   block_buf [16];
  int unsigned   fill;
  logic [60:0]   byte_count;
  digest_entry_t digest_q [$];
  digest_entry_t exp_word;
  int            err_count = 0;

  assign mismatches = err_count;

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned s);
    return (x >> s) | (x << (32 - s));
  endfunction

  task automatic restart_message();
    for (int i = 0; i < 8; i++) chain[i] = START_HASH[i];
    fill = 0;
    byte_count = '0;
  endtask

  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int t = 0; t < 16; t++) w[t] = block_buf[t];
    for (int t = 16; t < 64; t++) begin
      w[t] = w[t-16] + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) +
             w[t-7] + (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10));
    end
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
    for (int t = 0; t < 64; t++) begin
      t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g)) +
           ROUND_CONST[t] + w[t];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
  endtask

  task automatic put_byte(input logic [7:0] value);
    int unsigned pos;
    pos = fill % 64;
    if (pos % 4 == 0)
      block_buf[pos / 4] = {value, 24'h0};
    else
      block_buf[pos / 4] |= 32'(value) << (24 - 8 * (pos % 4));
    fill = pos + 1;
  endtask

  task automatic zero_words(input int unsigned limit);
    for (int unsigned i = (fill + 3) / 4; i < limit && i < 16; i++) block_buf[i] = '0;
  endtask

  task automatic hash_word(input logic [7:0] value, input logic has_byte, input logic ends);
    logic [63:0] bit_len;
    if (has_byte) begin
      put_byte(value);
      byte_count = byte_count + 61'd1;
      if (fill >= 64) begin
        compress();
        fill = 0;
      end
    end
    if (ends) begin
      put_byte(PAD_BYTE);
      // no room left for the length: spill into an extra block
      if (fill > 56) begin
        zero_words(16);
        compress();
        fill = 0;
      end
      zero_words(14);
      bit_len = {byte_count, 3'b000};
      block_buf[14] = bit_len[63:32];
      block_buf[15] = bit_len[31:0];
      compress();
      for (int i = 0; i < 8; i++)
        digest_q.push_back('{chain[i], 3'(i), 3'(i) == LAST_INDEX});
      restart_message();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      restart_message();
      digest_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (digest_q.size() == 0) begin
          $error("digest_word %h arrived with no digest pending", out_tdata);
          err_count++;
        end else begin
          exp_word = digest_q.pop_front();
          if (out_tdata !== exp_word.digest_word) begin
            $error("digest_word: expected %h, actual %h", exp_word.digest_word, out_tdata);
            err_count++;
          end
          if (out_tuser !== exp_word.word_index) begin
            $error("word_index: expected %0d, actual %0d", exp_word.word_index, out_tuser);
            err_count++;
          end
          if (out_tlast !== exp_word.last_word) begin
            $error("last_word: expected %b, actual %b", exp_word.last_word, out_tlast);
            err_count++;
          end
        end
      end
      if (in_tvalid && in_tready) hash_word(in_tdata, in_tuser[0], in_tlast);
    end
    words_owed <= digest_q.size();
  end

endmodule

[tb/testbench.sv]
// Testbench top for the SHA-256 stream hasher: clock, reset, stimulus, receiver and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 5000;
  localparam int LONG_HOLD = 400;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  int mismatches;
  int words_owed;
  int burst_left = 0;
  int items_sent = 0;
  int messages = 0;
  int idle_cycles = 0;
  bit hold_armed = 1'b0;

  sha256_stream_hasher dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  sha256_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .mismatches (mismatches),
    .words_owed (words_owed)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic send_word(input logic [7:0] value, input logic has_byte, input logic ends);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tuser  <= has_byte;
    in_tlast  <= ends;
    do @(posedge clk); while (!in_tready);
    if (has_byte || ends) items_sent++;
  endtask

  task automatic send_message(input int unsigned len, input bit end_only);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) send_word(8'($urandom), 1'b0, 1'b0);
      send_word(8'($urandom), 1'b1, (i == len - 1) && !end_only);
    end
    if (end_only || len == 0) send_word(8'($urandom), 1'b0, 1'b1);
    messages++;
  endtask

  // receiver: random ready patterns, plus one long hold-off at the first digest
  // word offered after hold_armed is set
  initial begin
    int seg_left;
    int seg_mode;
    int hold_left;
    bit hold_done;
    seg_left = 0;
    seg_mode = 0;
    hold_left = 0;
    hold_done = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_armed && !hold_done && out_tvalid) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_mode = $urandom_range(0, 2);
          seg_left = $urandom_range(5, 40);
        end
        seg_left--;
        case (seg_mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(8'h00, 1'b0, 1'b0);
    send_word(8'hff, 1'b0, 1'b1);  // empty message
    send_word(8'h00, 1'b1, 1'b1);
    send_word(8'hff, 1'b1, 1'b1);
    send_word(8'h61, 1'b1, 1'b0);
    send_word(8'h62, 1'b1, 1'b0);
    send_word(8'h63, 1'b1, 1'b1);
    send_word(8'h5a, 1'b1, 1'b0);
    send_word(8'hff, 1'b0, 1'b1);
    send_word(8'hff, 1'b0, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);

    hold_armed = 1'b1;
    send_message(56, 1'b0);  // length spills into a second block
    send_message(64, 1'b1);  // exact block multiple, end-only word
    while (items_sent < 150 || messages < 4) begin
      if ($urandom_range(0, 9) < 7)
        send_message($urandom_range(0, 8), $urandom_range(0, 3) == 0);
      else
        send_message($urandom_range(52, 68), $urandom_range(0, 3) == 0);
    end
    in_tvalid <= 1'b0;

    do @(posedge clk); while (words_owed != 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

[sim.f]
rtl/sh256_pkg.sv
rtl/sh256_core.sv
rtl/sha256_stream_hasher.sv
tb/sha256_checker.sv
tb/testbench.sv
